[hdl/periodic_task_timer_table_macros.svh]
// Assertion helpers for the timer table RTL.
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hdl/ptt_pkg.sv]
package ptt_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_SLOTS_DEF  = 32;
    localparam int IDENT_BITS_DEF = 8;

    // Fixed field widths
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 32;
    localparam int KIND_W      = 2;
    localparam int SLOT_W      = 5;
    localparam int IN_IDENT_W  = 8;
    localparam int OUT_IDENT_W = 8;

    // Result codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_POLL_EVAL,
        ST_POLL_DONE
    } t_state;

    // Due test result for one slot
    typedef struct packed {
        logic             due;
        logic [CNT_W-1:0] next_count;
    } t_eval_res;

endpackage

[hdl/ptt_ram.sv]
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/ptt_eval.sv]
module ptt_eval (
    input  logic [ptt_pkg::TIME_W-1:0] i_last_time,
    input  logic [ptt_pkg::TIME_W-1:0] i_interval,
    input  logic [ptt_pkg::CNT_W-1:0]  i_count,
    input  logic [ptt_pkg::TIME_W-1:0] i_now,
    output ptt_pkg::t_eval_res         o_res
);

    logic [ptt_pkg::TIME_W-1:0] due_time;

    // Deadline wraps at the time width, then an unsigned compare with now
    assign due_time         = i_last_time + i_interval;
    assign o_res.due        = (i_now >= due_time);
    assign o_res.next_count = i_count + ptt_pkg::CNT_W'(1);

endmodule

[hdl/periodic_task_timer_table.sv]
// Periodic task timer table.
// Input channel (i_in_valid / o_in_stall) takes one command per transfer:
// add (i_command 0) stores i_task_ident and i_interval_ms in the lowest
// free slot; poll (i_command 1) checks every slot against i_now_ms.
// Output channel (o_out_valid / i_out_stall) returns results; o_last marks
// the final result of each command. An add gives one result (added or full),
// a poll gives one result per fired slot or a single nothing-due result.
// An add scans the valid bits one slot per cycle. A poll reads, tests and
// writes back one slot per cycle through the slot memory while the output
// register has room for any result that a fired slot displaces. The next
// command is taken once the previous one has finished; a finished result
// may still wait in the output register. A stalled receiver holds the
// output register; the walk pauses only when a new result has no room,
// and resumes without loss.
// Reset clears all valid bits at once; slot memory contents need no clear.
module periodic_task_timer_table #(
    parameter int NUM_SLOTS  = ptt_pkg::NUM_SLOTS_DEF,
    parameter int IDENT_BITS = ptt_pkg::IDENT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [ptt_pkg::IN_IDENT_W-1:0]  i_task_ident,
    input  logic [ptt_pkg::TIME_W-1:0]      i_interval_ms,
    input  logic [ptt_pkg::TIME_W-1:0]      i_now_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ptt_pkg::KIND_W-1:0]      o_kind,
    output logic [ptt_pkg::SLOT_W-1:0]      o_slot,
    output logic [ptt_pkg::OUT_IDENT_W-1:0] o_fired_ident,
    output logic [ptt_pkg::CNT_W-1:0]       o_fire_count,
    output logic                            o_last
);

`include "periodic_task_timer_table_macros.svh"

    localparam int IW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TW      = ptt_pkg::TIME_W;
    localparam int CW      = ptt_pkg::CNT_W;
    localparam int SW      = ptt_pkg::SLOT_W;
    localparam int OIW     = ptt_pkg::OUT_IDENT_W;
    localparam int CNT_LO  = 0;
    localparam int LAST_LO = CW;
    localparam int INTV_LO = CW + TW;
    localparam int IDNT_LO = CW + 2 * TW;
    localparam int ENTRY_W = IDNT_LO + IDENT_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    // Sequencer and command registers
    ptt_pkg::t_state         r_state, n_state;
    logic [IW-1:0]           r_idx, n_idx;
    logic [IDENT_BITS-1:0]   r_ident, n_ident;
    logic [TW-1:0]           r_interval, n_interval;
    logic [TW-1:0]           r_now, n_now;
    logic [NUM_SLOTS-1:0]    r_valid, n_valid;

    // Fired result held until the next one shows whether it is the final one
    logic                    r_pend_valid, n_pend_valid;
    logic [IW-1:0]           r_pend_slot, n_pend_slot;
    logic [IDENT_BITS-1:0]   r_pend_ident, n_pend_ident;
    logic [CW-1:0]           r_pend_count, n_pend_count;

    // Output register
    logic                    r_out_valid, n_out_valid;
    ptt_pkg::t_kind          r_out_kind, n_out_kind;
    logic [SW-1:0]           r_out_slot, n_out_slot;
    logic [OIW-1:0]          r_out_ident, n_out_ident;
    logic [CW-1:0]           r_out_count, n_out_count;
    logic                    r_out_last, n_out_last;

    // Slot memory access
    logic                    ram_wr_en;
    logic [IW-1:0]           ram_wr_addr;
    logic [ENTRY_W-1:0]      ram_wr_data;
    logic [IW-1:0]           ram_rd_addr;
    logic [ENTRY_W-1:0]      ram_rd_data;

    logic [IDENT_BITS-1:0]   rd_ident;
    logic [TW-1:0]           rd_interval;
    logic [TW-1:0]           rd_last_time;
    logic [CW-1:0]           rd_count;
    ptt_pkg::t_eval_res      eval_res;

    logic                    accept;
    logic                    out_free;
    logic                    fire;

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Unpack the slot entry read last cycle
    assign rd_count     = ram_rd_data[CNT_LO  +: CW];
    assign rd_last_time = ram_rd_data[LAST_LO +: TW];
    assign rd_interval  = ram_rd_data[INTV_LO +: TW];
    assign rd_ident     = ram_rd_data[IDNT_LO +: IDENT_BITS];

    ptt_eval u_eval (
        .i_last_time (rd_last_time),
        .i_interval  (rd_interval),
        .i_count     (rd_count),
        .i_now       (r_now),
        .o_res       (eval_res)
    );

    assign o_in_stall = (r_state != ptt_pkg::ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_valid[r_idx] && eval_res.due;

    // Next state, memory access and result loading
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_ident      = r_ident;
        n_interval   = r_interval;
        n_now        = r_now;
        n_valid      = r_valid;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_ident = r_pend_ident;
        n_pend_count = r_pend_count;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_ident  = r_out_ident;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_idx;
        ram_wr_data  = {rd_ident, rd_interval, r_now, eval_res.next_count};
        ram_rd_addr  = '0;

        unique case (r_state)
            ptt_pkg::ST_IDLE: begin
                // Latch the command; slot 0 is read this cycle for a poll
                if (accept) begin
                    n_ident    = IDENT_BITS'(i_task_ident);
                    n_interval = i_interval_ms;
                    n_now      = i_now_ms;
                    n_idx      = '0;
                    n_state    = i_command ? ptt_pkg::ST_POLL_EVAL : ptt_pkg::ST_ADD;
                end
            end

            ptt_pkg::ST_ADD: begin
                // Scan for the lowest free slot
                if (!r_valid[r_idx]) begin
                    if (out_free) begin
                        ram_wr_en      = 1'b1;
                        ram_wr_data    = {r_ident, r_interval, TW'(0), CW'(0)};
                        n_valid[r_idx] = 1'b1;
                        n_out_valid    = 1'b1;
                        n_out_kind     = ptt_pkg::KIND_ADDED;
                        n_out_slot     = SW'(r_idx);
                        n_out_ident    = '0;
                        n_out_count    = '0;
                        n_out_last     = 1'b1;
                        n_idx          = '0;
                        n_state        = ptt_pkg::ST_IDLE;
                    end
                end else if (r_idx == LAST_IDX) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = ptt_pkg::KIND_FULL;
                        n_out_slot  = '0;
                        n_out_ident = '0;
                        n_out_count = '0;
                        n_out_last  = 1'b1;
                        n_idx       = '0;
                        n_state     = ptt_pkg::ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            ptt_pkg::ST_POLL_EVAL: begin
                // Test one slot; hold it when a displaced result has no room
                ram_rd_addr = r_idx;
                if (!(fire && r_pend_valid) || out_free) begin
                    ram_rd_addr = r_idx + IW'(1);
                    if (fire) begin
                        ram_wr_en = 1'b1;
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = ptt_pkg::KIND_FIRED;
                            n_out_slot  = SW'(r_pend_slot);
                            n_out_ident = OIW'(r_pend_ident);
                            n_out_count = r_pend_count;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_idx;
                        n_pend_ident = rd_ident;
                        n_pend_count = eval_res.next_count;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ptt_pkg::ST_POLL_DONE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end

            ptt_pkg::ST_POLL_DONE: begin
                // Release the final result of the poll
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_pend_valid) begin
                        n_out_kind  = ptt_pkg::KIND_FIRED;
                        n_out_slot  = SW'(r_pend_slot);
                        n_out_ident = OIW'(r_pend_ident);
                        n_out_count = r_pend_count;
                    end else begin
                        n_out_kind  = ptt_pkg::KIND_NONE;
                        n_out_slot  = '0;
                        n_out_ident = '0;
                        n_out_count = '0;
                    end
                    n_pend_valid = 1'b0;
                    n_idx        = '0;
                    n_state      = ptt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptt_pkg::ST_IDLE;
            r_idx        <= '0;
            r_valid      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_valid      <= n_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ident      <= n_ident;
        r_interval   <= n_interval;
        r_now        <= n_now;
        r_pend_slot  <= n_pend_slot;
        r_pend_ident <= n_pend_ident;
        r_pend_count <= n_pend_count;
        r_out_kind   <= n_out_kind;
        r_out_slot   <= n_out_slot;
        r_out_ident  <= n_out_ident;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_slot        = r_out_slot;
    assign o_fired_ident = r_out_ident;
    assign o_fire_count  = r_out_count;
    assign o_last        = r_out_last;

    // Checks on sequencing
    `PTT_ASSERT(a_idle_no_pend, (r_state == ptt_pkg::ST_IDLE) |-> !r_pend_valid, "pending result left at idle")
    `PTT_ASSERT(a_wr_marks_valid, ram_wr_en |=> r_valid[$past(ram_wr_addr)], "slot written but not valid")
    `PTT_ASSERT(a_none_is_last, (r_out_valid && (r_out_kind == ptt_pkg::KIND_NONE)) |-> r_out_last, "nothing-due result not final")
    `PTT_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!r_out_valid && (r_valid == '0)), "reset did not clear control state")

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      SLOTS         = ptt_pkg::NUM_SLOTS_DEF;
    localparam int      IDENT_KEEP    = ptt_pkg::IDENT_BITS_DEF;
    localparam int      IIW           = ptt_pkg::IN_IDENT_W;
    localparam int      OIW           = ptt_pkg::OUT_IDENT_W;
    localparam int      TW            = ptt_pkg::TIME_W;
    localparam int      CW            = ptt_pkg::CNT_W;
    localparam int      SW            = ptt_pkg::SLOT_W;
    localparam logic    CMD_ADD       = 1'b0;
    localparam logic    CMD_POLL      = 1'b1;
    localparam int      CLK_HALF_NS   = 4;
    localparam int      RESET_CYCLES  = 12;
    localparam int      MAX_REPORTS   = 10;
    localparam int      SETTLE_CYCLES = SLOTS + 8;
    localparam longint  TIMEOUT_NS    = 5_000_000;
    localparam logic [IIW-1:0] IDENT_MASK = IIW'((1 << IDENT_KEEP) - 1);

    typedef struct packed {
        ptt_pkg::t_kind kind;
        logic [SW-1:0]  slot;
        logic [OIW-1:0] ident;
        logic [CW-1:0]  count;
        logic           last;
    } t_result;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_stall;
    logic                          i_command     = CMD_ADD;
    logic [IIW-1:0]                i_task_ident  = '0;
    logic [TW-1:0]                 i_interval_ms = '0;
    logic [TW-1:0]                 i_now_ms      = '0;
    logic                          o_out_valid;
    logic                          i_out_stall   = 1'b0;
    logic [ptt_pkg::KIND_W-1:0]    o_kind;
    logic [SW-1:0]                 o_slot;
    logic [OIW-1:0]                o_fired_ident;
    logic [CW-1:0]                 o_fire_count;
    logic                          o_last;

    // Shadow copy of the task table
    bit                     slot_used     [SLOTS];
    logic [IIW-1:0]         slot_task     [SLOTS];
    logic [TW-1:0]          slot_period   [SLOTS];
    logic [TW-1:0]          slot_fired_at [SLOTS];
    logic [CW-1:0]          slot_fires    [SLOTS];

    t_result                pending_results[$];
    int                     in_idle_pct    = 0;
    int                     out_stall_pct  = 0;
    int                     mismatch_count = 0;
    logic [TW-1:0]          sim_clock_ms   = '0;

    periodic_task_timer_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_task_ident  (i_task_ident),
        .i_interval_ms (i_interval_ms),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_slot        (o_slot),
        .o_fired_ident (o_fired_ident),
        .o_fire_count  (o_fire_count),
        .o_last        (o_last)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Apply one command to the shadow table and queue the results it gives
    function automatic void model_command(input logic cmd,
                                          input logic [IIW-1:0] ident,
                                          input logic [TW-1:0] period,
                                          input logic [TW-1:0] now);
        t_result       r;
        logic [TW-1:0] due;
        int            fired;
        fired = 0;
        r = '{kind: ptt_pkg::KIND_FULL, slot: '0, ident: '0, count: '0, last: 1'b1};
        if (cmd == CMD_ADD) begin
            // take the lowest free slot, or report full
            for (int s = 0; s < SLOTS; s++) begin
                if (!slot_used[s]) begin
                    slot_used[s]     = 1'b1;
                    slot_task[s]     = ident & IDENT_MASK;
                    slot_period[s]   = period;
                    slot_fired_at[s] = '0;
                    slot_fires[s]    = '0;
                    r.kind = ptt_pkg::KIND_ADDED;
                    r.slot = SW'(s);
                    break;
                end
            end
            pending_results.push_back(r);
        end else begin
            // walk the slots in order; the due time wraps at 32 bits
            for (int s = 0; s < SLOTS; s++) begin
                due = slot_fired_at[s] + slot_period[s];
                if (slot_used[s] && now >= due) begin
                    slot_fired_at[s] = now;
                    slot_fires[s]    = slot_fires[s] + 1'b1;
                    r.kind  = ptt_pkg::KIND_FIRED;
                    r.slot  = SW'(s);
                    r.ident = OIW'(slot_task[s]);
                    r.count = slot_fires[s];
                    r.last  = 1'b0;
                    pending_results.push_back(r);
                    fired++;
                end
            end
            if (fired == 0) begin
                r.kind = ptt_pkg::KIND_NONE;
                pending_results.push_back(r);
            end else begin
                pending_results[pending_results.size() - 1].last = 1'b1;
            end
        end
    endfunction

    // Offer one command and hold it until the transfer happens
    task automatic send_command(input logic cmd, input logic [IIW-1:0] ident,
                                input logic [TW-1:0] period,
                                input logic [TW-1:0] now);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_task_ident  <= ident;
        i_interval_ms <= period;
        i_now_ms      <= now;
        do @(posedge i_clk); while (o_in_stall);
        model_command(cmd, ident, period, now);
    endtask

    task automatic add_task(input logic [IIW-1:0] ident, input logic [TW-1:0] period);
        send_command(CMD_ADD, ident, period, $urandom);
    endtask

    task automatic poll_at(input logic [TW-1:0] now);
        send_command(CMD_POLL, IIW'($urandom), $urandom, now);
    endtask

    // Drop valid and let every expected result come out
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_poll();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        poll_at('0);
        poll_at('1);
        wait_for_drain();
    endtask

    // Extreme identifiers and periods; nothing due on a filled slot; exact due hit
    task automatic test_add_and_due();
        in_idle_pct   = 30;
        out_stall_pct = 30;
        add_task(8'hFF, '1);
        add_task(8'h00, 32'd100);
        poll_at(32'd50);
        poll_at(32'd99);
        poll_at(32'd100);
        wait_for_drain();
    endtask

    // Due times that wrap past the top of the 32-bit range
    task automatic test_due_wrap();
        in_idle_pct   = 0;
        out_stall_pct = 50;
        poll_at('1);
        poll_at(32'hFFFF_FFFE);
        poll_at(32'd98);
        wait_for_drain();
    endtask

    // A zero period fires on every poll
    task automatic test_zero_interval();
        in_idle_pct   = 50;
        out_stall_pct = 0;
        add_task(8'h5A, '0);
        add_task(8'hA5, 32'd1);
        poll_at('0);
        poll_at('0);
        poll_at(32'd1);
        wait_for_drain();
    endtask

    // Mixed adds and polls against a drifting time base
    task automatic test_random_traffic(input int items, input int sender_idle,
                                       input int receiver_idle);
        logic           cmd;
        logic [IIW-1:0] ident;
        logic [TW-1:0]  period;
        logic [TW-1:0]  now;
        int             pick;
        in_idle_pct   = sender_idle;
        out_stall_pct = receiver_idle;
        repeat (items) begin
            cmd   = ($urandom_range(99) < 25) ? CMD_ADD : CMD_POLL;
            ident = IIW'($urandom);
            pick  = $urandom_range(99);
            if (pick < 40)      period = $urandom_range(50);
            else if (pick < 70) period = $urandom_range(2000);
            else if (pick < 90) period = $urandom;
            else                period = pick[0] ? '1 : '0;
            // advance the time base, now and then jump or hit an end of the range
            pick = $urandom_range(99);
            if (pick < 80)      sim_clock_ms = sim_clock_ms + $urandom_range(400);
            else if (pick < 92) sim_clock_ms = $urandom;
            else                sim_clock_ms = pick[0] ? '1 : '0;
            now = (cmd == CMD_POLL) ? sim_clock_ms : $urandom;
            send_command(cmd, ident, period, now);
        end
        wait_for_drain();
    endtask

    // Check each result transfer against the oldest expectation; randomize stall
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: kind %0d slot %0d ident 0x%02h count %0d last %0d",
                             o_kind, o_slot, o_fired_ident, o_fire_count, o_last);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_slot !== want.slot
                        || o_fired_ident !== want.ident || o_fire_count !== want.count
                        || o_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result mismatch: expected kind %0d slot %0d ident 0x%02h count %0d last %0d",
                                 want.kind, want.slot, want.ident, want.count, want.last);
                        $display("                 actual   kind %0d slot %0d ident 0x%02h count %0d last %0d",
                                 o_kind, o_slot, o_fired_ident, o_fire_count, o_last);
                    end
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_poll();
        test_add_and_due();
        test_due_wrap();
        test_zero_interval();
        test_random_traffic(100, 18, 80);
        test_random_traffic(100, 80, 18);
        test_random_traffic(110, 0, 0);
        if (mismatch_count == 0) begin
            $display("periodic_task_timer_table verification clean");
        end else begin
            $display("periodic_task_timer_table verification failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("periodic_task_timer_table verification failed");
        $finish;
    end

endmodule
